// File: hdl/crx_pkg.sv
// crx_pkg: shared types, constants and lane helpers for the chained rotate-xor cipher
// no dependencies; imported by every module under hdl
`timescale 1ns / 1ps
`default_nettype none

package crx_pkg;

    localparam int LANE_W    = 16;
    localparam int NUM_LANES = 4;
    localparam int BLOCK_W   = LANE_W * NUM_LANES;
    localparam int ROT_W     = 4;
    localparam int CNT_W     = 5;

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } t_cmd;

    typedef logic [LANE_W-1:0]  t_lane;
    typedef logic [BLOCK_W-1:0] t_block;

    // lane 0 of data, key and rot is always the lane the next stage works on
    typedef struct packed {
        t_cmd                            cmd;
        t_block                          data;
        t_block                          key;
        logic [NUM_LANES-1:0][ROT_W-1:0] rot;
        t_lane                           prev;
        t_block                          result;
    } t_stage;

    // rotation amount is the popcount modulo one full turn
    function automatic logic [ROT_W-1:0] lane_rot_amount(input t_lane v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < LANE_W; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n[ROT_W-1:0];
    endfunction

    function automatic t_lane rotl_lane(input t_lane v, input logic [ROT_W-1:0] r);
        logic [2*LANE_W-1:0] w;
        w = {v, v} << r;
        return w[2*LANE_W-1:LANE_W];
    endfunction

    function automatic t_lane rotr_lane(input t_lane v, input logic [ROT_W-1:0] r);
        logic [2*LANE_W-1:0] w;
        w = {v, v} >> r;
        return w[LANE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/crx_key_stage.sv
// crx_key_stage: first pipeline stage, works out the rotation amount of every key lane
// depends on crx_pkg
`timescale 1ns / 1ps
`default_nettype none

module crx_key_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire crx_pkg::t_cmd     i_cmd,
    input  wire crx_pkg::t_block   i_data,
    input  wire crx_pkg::t_block   i_key,
    input  wire crx_pkg::t_lane    i_chain_start,
    output logic                   o_valid,
    input  wire                    i_ready,
    output crx_pkg::t_stage        o_stage
);
    import crx_pkg::*;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_stage        = '0;
        n_stage.cmd    = i_cmd;
        n_stage.data   = i_data;
        n_stage.key    = i_key;
        n_stage.prev   = i_chain_start;
        for (int j = 0; j < NUM_LANES; j++) begin
            n_stage.rot[j] = lane_rot_amount(i_key[j*LANE_W +: LANE_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

// File: hdl/crx_lane_stage.sv
// crx_lane_stage: one lane of the chain per stage, then shifts the next lane into place
// depends on crx_pkg
`timescale 1ns / 1ps
`default_nettype none

module crx_lane_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire crx_pkg::t_stage   i_stage,
    output logic                   o_valid,
    input  wire                    i_ready,
    output crx_pkg::t_stage        o_stage
);
    import crx_pkg::*;

    logic       r_valid;
    t_stage     r_stage;
    t_stage     n_stage;
    t_lane      d;
    t_lane      k;
    logic [ROT_W-1:0] r;
    t_lane      o;
    t_lane      chain;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        d = i_stage.data[LANE_W-1:0];
        k = i_stage.key[LANE_W-1:0];
        r = i_stage.rot[0];
        if (i_stage.cmd == CMD_DECRYPT) begin
            o     = rotr_lane(d ^ k, r) ^ i_stage.prev;
            chain = d;
        end else begin
            o     = rotl_lane(d ^ i_stage.prev, r) ^ k;
            chain = o;
        end

        n_stage        = i_stage;
        n_stage.data   = i_stage.data >> LANE_W;
        n_stage.key    = i_stage.key >> LANE_W;
        n_stage.rot    = i_stage.rot >> ROT_W;
        n_stage.prev   = chain;
        // finished lanes enter at the top; after the last lane stage lane 0 sits at the bottom
        n_stage.result = {o, i_stage.result[BLOCK_W-1:LANE_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

// File: hdl/chained_rotate_xor_block_cipher.sv
// chained_rotate_xor_block_cipher: top level, key stage followed by four lane stages
// depends on crx_pkg, crx_key_stage and crx_lane_stage
//
// channel   direction  handshake          payload
// input     in         i_valid / o_ready  i_command, i_data_block, i_cipher_key
// result    out        o_valid / i_ready  o_result_block
// config    in         i_cfg_we           i_cfg_wdata (chain start word)
//
// five register stages: key popcount, then one stage per lane of the chain
// one transaction per cycle while the result side keeps i_ready high
// each stage takes a new transaction whenever it is empty or its contents move on
// synchronous active-low reset clears the valid bits and the chain start word
`timescale 1ns / 1ps
`default_nettype none

module chained_rotate_xor_block_cipher (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire                    i_command,
    input  wire [63:0]             i_data_block,
    input  wire [63:0]             i_cipher_key,
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic [63:0]            o_result_block,
    input  wire                    i_cfg_we,
    input  wire [15:0]             i_cfg_wdata
);
    import crx_pkg::*;

    t_lane  r_chain_start;
    t_cmd   cmd;

    logic   [NUM_LANES:0] stg_valid;
    logic   [NUM_LANES:0] stg_ready;
    t_stage stg [NUM_LANES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_start <= '0;
        end else if (i_cfg_we) begin
            r_chain_start <= i_cfg_wdata;
        end
    end

    assign cmd = t_cmd'(i_command);

    crx_key_stage u_key (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (cmd),
        .i_data        (i_data_block),
        .i_key         (i_cipher_key),
        .i_chain_start (r_chain_start),
        .o_valid       (stg_valid[0]),
        .i_ready       (stg_ready[0]),
        .o_stage       (stg[0])
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        crx_lane_stage u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_stage (stg[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_stage (stg[g+1])
        );
    end

    assign stg_ready[NUM_LANES] = i_ready;
    assign o_valid              = stg_valid[NUM_LANES];
    assign o_result_block       = stg[NUM_LANES].result;

endmodule

`default_nettype wire
